/* sv/spiram_pkg.sv */
package spiram_pkg;

  // bits per serial byte and the width of the bit counter
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CNT_W     = 3;
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BYTE_BITS - 1);

  // operation codes
  localparam logic [1:0] OP_SINGLE_READ  = 2'd0;
  localparam logic [1:0] OP_SINGLE_WRITE = 2'd1;
  localparam logic [1:0] OP_BURST_READ   = 2'd2;
  localparam logic [1:0] OP_BURST_WRITE  = 2'd3;

  // transfer phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

  // one tick offered on the input channel
  typedef struct packed {
    logic       request_valid;
    logic [1:0] operation;
    logic [6:0] reg_address;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       miso_level;
  } in_item_t;

  // pin levels and read data for one tick
  typedef struct packed {
    logic       chip_select_n;
    logic       serial_clock;
    logic       mosi_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       ready_res;
  } out_item_t;

  // classified tick as held in the queue
  typedef struct packed {
    logic       req;
    logic       start;
    logic       is_write;
    logic       is_burst;
    logic [7:0] addr_byte;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       miso_level;
  } qent_t;

endpackage

/* sv/spiram_front.sv */
module spiram_front (
  input  spiram_pkg::in_item_t item_i,
  output spiram_pkg::qent_t    ent_o
);

  logic is_write;
  logic is_burst;

  // decode the operation code
  assign is_write = (item_i.operation == spiram_pkg::OP_SINGLE_WRITE) ||
                    (item_i.operation == spiram_pkg::OP_BURST_WRITE);
  assign is_burst = (item_i.operation == spiram_pkg::OP_BURST_READ) ||
                    (item_i.operation == spiram_pkg::OP_BURST_WRITE);

  // classify: a burst whose first byte is last never starts
  always_comb begin
    ent_o.req        = item_i.request_valid;
    ent_o.start      = item_i.request_valid && !(is_burst && item_i.last_byte);
    ent_o.is_write   = is_write;
    ent_o.is_burst   = is_burst;
    ent_o.addr_byte  = {is_write, item_i.reg_address};
    ent_o.data_byte  = item_i.data_byte;
    ent_o.last_byte  = item_i.last_byte;
    ent_o.miso_level = item_i.miso_level;
  end

endmodule

/* sv/spiram_queue.sv */
module spiram_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spiram_pkg::qent_t push_ent,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output spiram_pkg::qent_t head_ent
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  spiram_pkg::qent_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_ent  = slot_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_ent;
    end
  end

  // the fill count never runs past the depth
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= FULL_CNT)
    else $error("queue count overflow");

endmodule

/* sv/spiram_back.sv */
module spiram_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ent_valid,
  input  spiram_pkg::qent_t     ent,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spiram_pkg::out_item_t out_data
);

  spiram_pkg::phase_t          phase_r, phase_nxt;
  logic [spiram_pkg::CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                  shift_r, shift_nxt;
  logic [7:0]                  held_r, held_nxt;
  logic                        clk_high_r, clk_high_nxt;
  logic                        is_write_r, is_write_nxt;
  logic                        final_r, final_nxt;
  logic                        sel_r, sel_nxt;
  logic                        out_valid_r;
  spiram_pkg::out_item_t       out_data_r, res;
  logic                        reading;
  logic [7:0]                  shifted;

  // a tick is taken when the output register is free or being emptied
  assign take      = ent_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign reading = (phase_r == spiram_pkg::PH_DATA) && !is_write_r;
  assign shifted = {shift_r[6:0], reading && ent.miso_level};

  // one tick of the serial engine
  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    held_nxt     = held_r;
    clk_high_nxt = clk_high_r;
    is_write_nxt = is_write_r;
    final_nxt    = final_r;
    sel_nxt      = sel_r;

    res.chip_select_n = !sel_r;
    res.serial_clock  = 1'b0;
    res.mosi_level    = 1'b1;
    res.read_byte     = '0;
    res.read_valid    = 1'b0;
    res.ready_res     = 1'b0;

    unique case (phase_r)
      spiram_pkg::PH_IDLE: begin
        res.ready_res = 1'b1;
        if (ent.start) begin
          is_write_nxt = ent.is_write;
          final_nxt    = !ent.is_burst;
          held_nxt     = ent.data_byte;
          shift_nxt    = ent.addr_byte;
          bit_cnt_nxt  = '0;
          clk_high_nxt = 1'b0;
          sel_nxt      = 1'b1;
          phase_nxt    = spiram_pkg::PH_ADDR;
        end
      end
      spiram_pkg::PH_WAIT: begin
        res.ready_res = 1'b1;
        if (ent.req) begin
          shift_nxt    = is_write_r ? ent.data_byte : 8'h00;
          final_nxt    = ent.last_byte;
          bit_cnt_nxt  = '0;
          clk_high_nxt = 1'b0;
          phase_nxt    = spiram_pkg::PH_DATA;
        end
      end
      default: begin
        res.mosi_level = reading ? 1'b1 : shift_r[7];
        if (!clk_high_r) begin
          clk_high_nxt = 1'b1;
        end else begin
          res.serial_clock = 1'b1;
          clk_high_nxt     = 1'b0;
          shift_nxt        = shifted;
          if (bit_cnt_r == spiram_pkg::LAST_BIT) begin
            bit_cnt_nxt = '0;
            if (phase_r == spiram_pkg::PH_ADDR) begin
              phase_nxt = spiram_pkg::PH_DATA;
              shift_nxt = is_write_r ? held_r : 8'h00;
            end else begin
              if (reading) begin
                res.read_valid = 1'b1;
                res.read_byte  = shifted;
              end
              if (final_r) begin
                phase_nxt = spiram_pkg::PH_IDLE;
                sel_nxt   = 1'b0;
              end else begin
                phase_nxt = spiram_pkg::PH_WAIT;
              end
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + spiram_pkg::CNT_W'(1);
          end
        end
      end
    endcase
  end

  // engine state advances once per taken tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= spiram_pkg::PH_IDLE;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      held_r     <= '0;
      clk_high_r <= 1'b0;
      is_write_r <= 1'b0;
      final_r    <= 1'b0;
      sel_r      <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      held_r     <= held_nxt;
      clk_high_r <= clk_high_nxt;
      is_write_r <= is_write_nxt;
      final_r    <= final_nxt;
      sel_r      <= sel_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  // a completed read byte comes with clock high and chip select low
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.read_valid) |->
      (out_data_r.serial_clock && !out_data_r.chip_select_n))
    else $error("read byte outside a selected clock-high tick");

  // chip select follows the phase: idle only when deselected
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == spiram_pkg::PH_IDLE) == !sel_r)
    else $error("chip select out of step with phase");

  // the address byte hands over to the data byte after its last bit
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && phase_r == spiram_pkg::PH_ADDR && clk_high_r &&
     bit_cnt_r == spiram_pkg::LAST_BIT) |=> (phase_r == spiram_pkg::PH_DATA))
    else $error("address byte did not hand over to data");

endmodule

/* sv/spi_register_access_master_core.sv */
// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | in_data  (one tick: request and sampled miso)
// result   | out_valid | out_stall | out_data (pin levels, read byte, ready flag)
//
// one tick in and one result out per cycle, sustained, as long as out_stall is low
// a tick passes the classifier, a QUEUE_DEPTH-entry queue and the serial engine;
// its result appears in the cycle after the engine takes it from the queue head
// reset (synchronous, rst_n low) empties the queue and returns the engine to idle
// in_stall rises only when the queue is full; a stalled result holds in out_data
module spi_register_access_master_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  spiram_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spiram_pkg::out_item_t out_data
);

  spiram_pkg::qent_t cls_ent;
  spiram_pkg::qent_t head_ent;
  logic              q_full;
  logic              q_not_empty;
  logic              q_take;

  // front: classify the incoming tick
  spiram_front u_front (
    .item_i (in_data),
    .ent_o  (cls_ent)
  );

  // queue between front and engine
  spiram_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_ent  (cls_ent),
    .full      (q_full),
    .pop       (q_take),
    .not_empty (q_not_empty),
    .head_ent  (head_ent)
  );

  assign in_stall = q_full;

  // back: serial engine and output register
  spiram_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (q_not_empty),
    .ent       (head_ent),
    .take      (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_TICKS  = 1000;
  localparam int CALM_TICKS  = 150;
  localparam int LONG_HOLD   = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] WRITE_FLAG = 8'h80;

  // pin levels of an idle tick that is ready for a request
  localparam spiram_pkg::out_item_t IDLE_LEVELS = '{chip_select_n: 1'b1,
                                                    serial_clock: 1'b0,
                                                    mosi_level: 1'b1, read_byte: 8'h00,
                                                    read_valid: 1'b0, ready_res: 1'b1};

  typedef struct {
    spiram_pkg::in_item_t item;
    int                   reps;
    bit                   typed;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  spiram_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  spiram_pkg::out_item_t out_data;

  // predicted engine state
  spiram_pkg::phase_t eng_phase;
  logic [2:0]         eng_bits;
  logic [7:0]         eng_shift;
  logic               eng_clk_high;
  logic [1:0]         eng_op;
  logic               eng_final;
  logic               eng_select;
  logic [7:0]         eng_held;

  spiram_pkg::out_item_t pin_levels_q[$];
  spiram_pkg::out_item_t seen_want;
  dir_row_t              dir_rows[$];
  spiram_pkg::in_item_t  rand_tick;
  int                    errors;
  int                    send_gap_pct;
  int                    stall_pct;
  bit                    calm;
  bit                    hold_pending;

  spi_register_access_master_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit writes(logic [1:0] op);
    return op == spiram_pkg::OP_SINGLE_WRITE || op == spiram_pkg::OP_BURST_WRITE;
  endfunction

  function automatic bit bursts(logic [1:0] op);
    return op == spiram_pkg::OP_BURST_READ || op == spiram_pkg::OP_BURST_WRITE;
  endfunction

  // one half period of the serial clock: pin levels for this tick, then advance
  function automatic spiram_pkg::out_item_t pin_levels_for(spiram_pkg::in_item_t t);
    spiram_pkg::out_item_t r;
    logic                  reading;
    r = '{chip_select_n: ~eng_select, serial_clock: 1'b0, mosi_level: 1'b1,
          read_byte: 8'h00, read_valid: 1'b0, ready_res: 1'b0};
    case (eng_phase)
      spiram_pkg::PH_IDLE: begin
        r.ready_res = 1'b1;
        // a burst whose first byte is already the last one is dropped
        if (t.request_valid && !(bursts(t.operation) && t.last_byte)) begin
          eng_op       = t.operation;
          eng_final    = bursts(t.operation) ? t.last_byte : 1'b1;
          eng_held     = t.data_byte;
          eng_shift    = {1'b0, t.reg_address} | (writes(t.operation) ? WRITE_FLAG : 8'h00);
          eng_bits     = '0;
          eng_clk_high = 1'b0;
          eng_select   = 1'b1;
          eng_phase    = spiram_pkg::PH_ADDR;
        end
      end
      spiram_pkg::PH_WAIT: begin
        r.ready_res = 1'b1;
        // next burst byte keeps the burst kind
        if (t.request_valid) begin
          eng_shift    = writes(eng_op) ? t.data_byte : 8'h00;
          eng_final    = t.last_byte;
          eng_bits     = '0;
          eng_clk_high = 1'b0;
          eng_phase    = spiram_pkg::PH_DATA;
        end
      end
      default: begin
        reading      = (eng_phase == spiram_pkg::PH_DATA) && !writes(eng_op);
        r.mosi_level = reading ? 1'b1 : eng_shift[7];
        if (!eng_clk_high) begin
          eng_clk_high = 1'b1;
        end else begin
          r.serial_clock = 1'b1;
          eng_clk_high   = 1'b0;
          eng_shift      = {eng_shift[6:0], reading ? t.miso_level : 1'b0};
          if (eng_bits == spiram_pkg::LAST_BIT) begin
            eng_bits = '0;
            if (eng_phase == spiram_pkg::PH_ADDR) begin
              eng_phase = spiram_pkg::PH_DATA;
              eng_shift = writes(eng_op) ? eng_held : 8'h00;
            end else begin
              if (reading) begin
                r.read_valid = 1'b1;
                r.read_byte  = eng_shift;
              end
              if (eng_final) begin
                eng_phase  = spiram_pkg::PH_IDLE;
                eng_select = 1'b0;
              end else begin
                eng_phase = spiram_pkg::PH_WAIT;
              end
            end
          end else begin
            eng_bits = eng_bits + 3'd1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic dir_row_t tick_row(int req, logic [1:0] op, logic [6:0] adr,
                                        logic [7:0] dat, int last, int miso,
                                        int reps, int typed);
    dir_row_t d;
    d.item  = '{request_valid: 1'(req), operation: op, reg_address: adr, data_byte: dat,
                last_byte: 1'(last), miso_level: 1'(miso)};
    d.reps  = reps;
    d.typed = 1'(typed);
    return d;
  endfunction

  // offer one tick, wait until it is accepted, then record what it should produce
  task automatic send_tick(spiram_pkg::in_item_t it, bit typed);
    int                    gap;
    spiram_pkg::out_item_t want;
    gap = (!calm && $urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = pin_levels_for(it);
    if (typed) want = IDLE_LEVELS;
    pin_levels_q.push_back(want);
  endtask

  // lower valid and wait until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pin_levels_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none actual %h", $time, out_data);
      end else begin
        seen_want = pin_levels_q.pop_front();
        check_field("chip_select_n", seen_want.chip_select_n, out_data.chip_select_n);
        check_field("serial_clock", seen_want.serial_clock, out_data.serial_clock);
        check_field("mosi_level", seen_want.mosi_level, out_data.mosi_level);
        check_field("read_byte", seen_want.read_byte, out_data.read_byte);
        check_field("read_valid", seen_want.read_valid, out_data.read_valid);
        check_field("ready_res", seen_want.ready_res, out_data.ready_res);
      end
    end
  end

  // receiver stalls: random bursts, quiet stretches, one long hold-off
  initial begin
    int cyc;
    out_stall = 1'b0;
    stall_pct = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (cyc % 300 == 0) stall_pct = 10 * $urandom_range(0, 3);
      cyc++;
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // cycle limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("spi_register_access_master_core test failed");
    $finish;
  end

  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;
    errors       = 0;
    calm         = 1'b0;
    hold_pending = 1'b0;
    send_gap_pct = 20;
    eng_phase    = spiram_pkg::PH_IDLE;
    eng_bits     = '0;
    eng_shift    = '0;
    eng_clk_high = 1'b0;
    eng_op       = spiram_pkg::OP_SINGLE_READ;
    eng_final    = 1'b0;
    eng_select   = 1'b0;
    eng_held     = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks: idle, singles, short bursts, full bursts, busy requests
    dir_rows = '{
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 3,  1),  // idle after reset
      tick_row(1, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 1,  1),  // accept tick is idle
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 32, 0),  // reads all ones
      tick_row(1, spiram_pkg::OP_SINGLE_WRITE, 7'h7F, 8'hFF, 0, 1, 1,  1),
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 0, 32, 0),
      tick_row(1, spiram_pkg::OP_BURST_READ,   7'h11, 8'h00, 1, 0, 1,  1),  // short burst dropped
      tick_row(1, spiram_pkg::OP_BURST_WRITE,  7'h22, 8'hFF, 1, 1, 1,  1),  // short burst dropped
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 1,  1),
      tick_row(1, spiram_pkg::OP_BURST_READ,   7'h55, 8'hFF, 0, 0, 1,  1),
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 16, 0),  // miso ignored
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 0, 16, 0),
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 3,  0),  // burst wait
      tick_row(1, spiram_pkg::OP_SINGLE_WRITE, 7'h7F, 8'hFF, 0, 1, 1,  0),  // op ignored in wait
      tick_row(1, spiram_pkg::OP_BURST_WRITE,  7'h00, 8'h00, 1, 1, 8,  0),  // busy ignored
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 0, 8,  0),
      tick_row(1, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 1, 1, 1,  0),  // last byte of burst
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 16, 0),
      tick_row(1, spiram_pkg::OP_BURST_WRITE,  7'h2A, 8'h00, 0, 1, 1,  0),
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 32, 0),
      tick_row(1, spiram_pkg::OP_BURST_READ,   7'h00, 8'hA5, 0, 0, 1,  0),  // keeps write kind
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 16, 0),
      tick_row(1, spiram_pkg::OP_SINGLE_READ,  7'h7F, 8'h5A, 1, 1, 1,  0),
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 0, 16, 0),
      tick_row(1, spiram_pkg::OP_SINGLE_READ,  7'h40, 8'h00, 1, 0, 1,  1),  // last ignored
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 1, 32, 0),
      tick_row(0, spiram_pkg::OP_SINGLE_READ,  7'h00, 8'h00, 0, 0, 2,  1)
    };
    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) send_tick(dir_rows[r].item, dir_rows[r].typed);
    end

    // random ticks, shaped by the predicted phase so transfers run to the end
    for (int n = 0; n < RAND_TICKS; n++) begin
      if (n % 100 == 0) send_gap_pct = 10 * $urandom_range(0, 3);
      if (n == 400) hold_pending = 1'b1;
      if (n == 800) drain_results();
      if (n == RAND_TICKS - CALM_TICKS) calm = 1'b1;
      rand_tick = spiram_pkg::in_item_t'($urandom);
      case (eng_phase)
        spiram_pkg::PH_IDLE: begin
          rand_tick.request_valid = ($urandom_range(0, 99) < 85);
          if (bursts(rand_tick.operation))
            rand_tick.last_byte = ($urandom_range(0, 99) < 12);
        end
        spiram_pkg::PH_WAIT: begin
          rand_tick.request_valid = ($urandom_range(0, 99) < 80);
          rand_tick.last_byte     = ($urandom_range(0, 99) < 40);
        end
        default: begin
          rand_tick.request_valid = ($urandom_range(0, 99) < 15);
        end
      endcase
      send_tick(rand_tick, 1'b0);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("spi_register_access_master_core test passed");
    end else begin
      $display("spi_register_access_master_core test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/spiram_pkg.sv
sv/spiram_front.sv
sv/spiram_queue.sv
sv/spiram_back.sv
sv/spi_register_access_master_core.sv
tb/sv/tb.sv
